FILE: hdl/debounced_input_card_macros.svh
// ----------------------------------------------------------------------------
// debounced_input_card_macros.svh
// Assertion macros shared by the input card RTL. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_INPUT_CARD_MACROS_SVH
`define DEBOUNCED_INPUT_CARD_MACROS_SVH
`ifndef SYNTH
// property holds in the same cycle
`define DIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define DIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DIC_ASSERT(label, clk, rst_n, prop, msg)
`define DIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/dic_pkg.sv
// ----------------------------------------------------------------------------
// dic_pkg
// Shared constants, types and LED tables of the debounced input card.
// ----------------------------------------------------------------------------
package dic_pkg;

    localparam int CHANNELS = 6;
    localparam int POS_W    = 3;
    localparam int CH_IDX_W = 3;

    localparam logic [7:0] CENTRE        = 8'd128;
    localparam logic [6:0] LIMIT_DEFAULT = 7'd25;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_READ_ONE = 2'd1,
        OP_READ_ALL = 2'd2
    } op_t;

    typedef struct packed {
        logic [2:0] enable;
        logic [2:0] level;
    } led_t;

    typedef struct packed {
        logic       is_response;
        logic [5:0] read_value;
        led_t       led;
    } res_t;

    localparam logic [2:0] LED_EN_TAB [0:5] = '{3'h3, 3'h3, 3'h6, 3'h6, 3'h5, 3'h5};
    localparam logic [2:0] LED_LV_TAB [0:5] = '{3'h1, 3'h2, 3'h2, 3'h4, 3'h1, 3'h4};

endpackage

FILE: hdl/dic_lane.sv
// ----------------------------------------------------------------------------
// dic_lane
// One channel: saturating integrator with hysteresis and closed state.
// ----------------------------------------------------------------------------
`include "debounced_input_card_macros.svh"

module dic_lane
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       raw_level,
    input  logic [6:0] limit,
    output logic       closed,
    output logic       closed_next
);

    logic [7:0] integ_reg;
    logic [7:0] integ_next;
    logic       closed_reg;
    logic [7:0] hi;
    logic [7:0] lo;

    assign hi = dic_pkg::CENTRE + {1'b0, limit};
    assign lo = dic_pkg::CENTRE - {1'b0, limit};

    always_comb
    begin
        integ_next  = integ_reg;
        closed_next = closed_reg;
        if (tick)
        begin
            if (!raw_level)
            begin
                if (integ_reg >= hi)
                begin
                    integ_next  = hi;
                    closed_next = 1'b1;
                end
                else
                begin
                    integ_next = integ_reg + 8'd1;
                end
            end
            else
            begin
                if (integ_reg <= lo)
                begin
                    integ_next  = lo;
                    closed_next = 1'b0;
                end
                else
                begin
                    integ_next = integ_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg  <= dic_pkg::CENTRE;
            closed_reg <= 1'b0;
        end
        else
        begin
            integ_reg  <= integ_next;
            closed_reg <= closed_next;
        end
    end

    assign closed = closed_reg;

    `DIC_ASSERT(a_integ_nonzero, clk, rst_n, integ_reg != 8'd0, "integrator reached zero")
    `DIC_ASSERT_NEXT(a_integ_hold, clk, rst_n, !tick, $stable(integ_reg), "integrator moved")
    `DIC_ASSERT_NEXT(a_closed_hold, clk, rst_n, !tick, $stable(closed_reg), "state moved")

endmodule

FILE: hdl/dic_merge.sv
// ----------------------------------------------------------------------------
// dic_merge
// Combines lane states: LED round-robin, read mux, result assembly.
// ----------------------------------------------------------------------------
`include "debounced_input_card_macros.svh"

module dic_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    op,
    input  logic [7:0]                    channel,
    input  logic [dic_pkg::CHANNELS-1:0]  closed_vec,
    input  logic [dic_pkg::CHANNELS-1:0]  closed_next_vec,
    output dic_pkg::res_t                 res
);

    logic [dic_pkg::POS_W-1:0] pos_reg;
    logic [dic_pkg::POS_W-1:0] pos_next;
    dic_pkg::led_t             led_reg;
    dic_pkg::led_t             led_next;
    logic [7:0]                closed_pad;
    logic [7:0]                closed_next_pad;
    logic                      tick;

    assign closed_pad      = 8'(closed_vec);
    assign closed_next_pad = 8'(closed_next_vec);
    assign tick            = accept && (op == dic_pkg::OP_TICK);

    always_comb
    begin
        pos_next = pos_reg;
        led_next = led_reg;
        if (tick)
        begin
            if (closed_next_pad[pos_reg])
            begin
                led_next.enable = dic_pkg::LED_EN_TAB[pos_reg];
                led_next.level  = dic_pkg::LED_LV_TAB[pos_reg];
            end
            else
            begin
                led_next = '0;
            end
            if (pos_reg == dic_pkg::POS_W'(dic_pkg::CHANNELS - 1))
                pos_next = '0;
            else
                pos_next = pos_reg + dic_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        res.is_response = 1'b0;
        res.read_value  = '0;
        res.led         = led_next;
        unique case (op)
            dic_pkg::OP_TICK:
            begin
                res.is_response = 1'b0;
            end
            dic_pkg::OP_READ_ONE:
            begin
                res.is_response = 1'b1;
                if (channel < 8'(dic_pkg::CHANNELS))
                    res.read_value = 6'(closed_pad[channel[dic_pkg::CH_IDX_W-1:0]]);
            end
            dic_pkg::OP_READ_ALL:
            begin
                res.is_response = 1'b1;
                res.read_value  = 6'(closed_vec);
            end
            default:
            begin
                res.is_response = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            led_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            led_reg <= led_next;
        end
    end

    `DIC_ASSERT(a_pos_range, clk, rst_n, pos_reg < dic_pkg::POS_W'(dic_pkg::CHANNELS), "bad LED position")
    `DIC_ASSERT(a_led_off_or_driven, clk, rst_n, (led_reg == '0) || (led_reg.enable != 3'd0), "level without drive")
    `DIC_ASSERT_NEXT(a_led_hold, clk, rst_n, !tick, $stable(led_reg) && $stable(pos_reg), "LED moved without tick")

endmodule

FILE: hdl/dic_out.sv
// ----------------------------------------------------------------------------
// dic_out
// Output register with one skid entry so input acceptance does not wait
// on the downstream stall.
// ----------------------------------------------------------------------------
`include "debounced_input_card_macros.svh"

module dic_out
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dic_pkg::res_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_stall,
    output dic_pkg::res_t out_data
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    dic_pkg::res_t out_data_reg;
    dic_pkg::res_t skid_data_reg;
    logic          out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        else if (push)
            skid_data_reg <= push_data;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `DIC_ASSERT(a_no_push_full, clk, rst_n, !(push && skid_valid_reg), "transaction into full skid")
    `DIC_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg, "skid without output")
    `DIC_ASSERT_NEXT(a_skid_catch, clk, rst_n, push && out_valid_reg && out_stall, skid_valid_reg, "transaction lost")

endmodule

FILE: hdl/debounced_input_card.sv
// ----------------------------------------------------------------------------
// debounced_input_card
// Six-channel digital input card with integrating debounce and a
// charlieplexed status LED. One transaction per clock unless in_stall is
// high; all six channel integrators update side by side. A result goes to
// the output register, or to the one-entry skid stage while the output is
// stalled, so the input stalls only when two results are held. The user
// must write debounce_limit through its own valid/ready port (always
// ready) only while the card is idle; the card does not enforce this.
// ----------------------------------------------------------------------------
module debounced_input_card
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [5:0] raw_levels,
    input  logic [7:0] channel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_response,
    output logic [5:0] read_value,
    output logic [2:0] led_enable,
    output logic [2:0] led_level,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] debounce_limit
);

    logic [6:0]                         limit_reg;
    logic                               accept;
    logic                               tick;
    logic [dic_pkg::CHANNELS-1:0]       closed_vec;
    logic [dic_pkg::CHANNELS-1:0]       closed_next_vec;
    dic_pkg::res_t                      res;
    dic_pkg::res_t                      out_data;
    logic                               full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= dic_pkg::LIMIT_DEFAULT;
        else if (cfg_valid && cfg_ready)
            limit_reg <= debounce_limit;
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign tick     = accept && (op == dic_pkg::OP_TICK);

    for (genvar n = 0; n < dic_pkg::CHANNELS; n++)
    begin : g_lane
        dic_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .tick        (tick),
            .raw_level   (raw_levels[n]),
            .limit       (limit_reg),
            .closed      (closed_vec[n]),
            .closed_next (closed_next_vec[n])
        );
    end

    dic_merge u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (op),
        .channel         (channel),
        .closed_vec      (closed_vec),
        .closed_next_vec (closed_next_vec),
        .res             (res)
    );

    dic_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign is_response = out_data.is_response;
    assign read_value  = out_data.read_value;
    assign led_enable  = out_data.led.enable;
    assign led_level   = out_data.led.level;

endmodule

FILE: sim/tb_debounced_input_card.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounced_input_card
// Drives reads, ticks and unused opcodes into the input card under several
// debounce limits. Each transaction is predicted by a local copy of the
// channel integrators and the LED scan, and every result is compared field
// by field. Random idle and stall bursts on both sides, then a steady run.
// ----------------------------------------------------------------------------
module tb_debounced_input_card;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] SCAN_ENABLE [0:5] = '{3'h3, 3'h3, 3'h6, 3'h6, 3'h5, 3'h5};
    localparam logic [2:0] SCAN_LEVEL  [0:5] = '{3'h1, 3'h2, 3'h2, 3'h4, 3'h1, 3'h4};

    typedef struct {
        logic       is_response;
        logic [5:0] read_value;
        logic [2:0] led_enable;
        logic [2:0] led_level;
    } card_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op = dic_pkg::OP_TICK;
    logic [5:0] raw_levels = '0;
    logic [7:0] channel = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       is_response;
    logic [5:0] read_value;
    logic [2:0] led_enable;
    logic [2:0] led_level;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] debounce_limit = dic_pkg::LIMIT_DEFAULT;

    // predicted card state
    logic [6:0] limit_q;
    logic [7:0] integ_q [dic_pkg::CHANNELS];
    logic       closed_q [dic_pkg::CHANNELS];
    logic [2:0] scan_pos_q;
    logic [2:0] scan_en_q;
    logic [2:0] scan_lv_q;

    card_result_t pending_results[$];
    int           error_count = 0;
    bit           quiet = 1'b0;

    debounced_input_card dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .raw_levels     (raw_levels),
        .channel        (channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_response    (is_response),
        .read_value     (read_value),
        .led_enable     (led_enable),
        .led_level      (led_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .debounce_limit (debounce_limit)
    );

    always #5 clk = ~clk;

    function automatic void reset_card_model();
        limit_q = dic_pkg::LIMIT_DEFAULT;
        for (int n = 0; n < dic_pkg::CHANNELS; n++)
        begin
            integ_q[n]  = dic_pkg::CENTRE;
            closed_q[n] = 1'b0;
        end
        scan_pos_q = '0;
        scan_en_q  = '0;
        scan_lv_q  = '0;
    endfunction

    function automatic void advance_debounce(logic [5:0] levels);
        int top;
        int bottom;
        int v;
        top    = int'(dic_pkg::CENTRE) + int'(limit_q);
        bottom = int'(dic_pkg::CENTRE) - int'(limit_q);
        for (int n = 0; n < dic_pkg::CHANNELS; n++)
        begin
            v = int'(integ_q[n]);
            if (!levels[n])
            begin
                v = v + 1;
                if (v > top)
                begin
                    v = top;
                    closed_q[n] = 1'b1;
                end
            end
            else
            begin
                v = v - 1;
                if (v < bottom)
                begin
                    v = bottom;
                    closed_q[n] = 1'b0;
                end
            end
            integ_q[n] = v[7:0];
        end
        if (closed_q[scan_pos_q])
        begin
            scan_en_q = SCAN_ENABLE[scan_pos_q];
            scan_lv_q = SCAN_LEVEL[scan_pos_q];
        end
        else
        begin
            scan_en_q = '0;
            scan_lv_q = '0;
        end
        scan_pos_q = (scan_pos_q == dic_pkg::CHANNELS - 1) ? 3'd0 : scan_pos_q + 3'd1;
    endfunction

    function automatic card_result_t card_response(logic [1:0] kind, logic [5:0] levels,
                                                   logic [7:0] ch);
        card_result_t r;
        r.is_response = 1'b0;
        r.read_value  = '0;
        if (kind == dic_pkg::OP_TICK)
            advance_debounce(levels);
        else if (kind == dic_pkg::OP_READ_ONE)
        begin
            r.is_response = 1'b1;
            if (ch < dic_pkg::CHANNELS)
                r.read_value = {5'd0, closed_q[ch[2:0]]};
        end
        else if (kind == dic_pkg::OP_READ_ALL)
        begin
            r.is_response = 1'b1;
            for (int n = 0; n < dic_pkg::CHANNELS; n++)
                r.read_value[n] = closed_q[n];
        end
        r.led_enable = scan_en_q;
        r.led_level  = scan_lv_q;
        return r;
    endfunction

    // one transaction on the input channel; valid stays high afterwards
    task automatic send_item(logic [1:0] kind, logic [5:0] levels, logic [7:0] ch);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        raw_levels <= levels;
        channel    <= ch;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(card_response(kind, levels, ch));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [6:0] value);
        in_valid <= 1'b0;
        wait_drained();
        cfg_valid      <= 1'b1;
        debounce_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_q = value;
    endtask

    // held switch pattern with occasional bounce noise, mixed with reads and unused opcodes
    task automatic drive_mixed_traffic(int count, int hold);
        logic [5:0] pressed;
        logic [5:0] noise;
        int         sel;
        pressed = 6'($urandom);
        repeat (count)
        begin
            if ($urandom_range(0, hold) == 0)
                pressed = 6'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                noise = 6'($urandom & $urandom & $urandom & $urandom);
                send_item(dic_pkg::OP_TICK, pressed ^ noise, 8'($urandom));
            end
            else if (sel < 82)
                send_item(dic_pkg::OP_READ_ONE, 6'($urandom),
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom));
            else if (sel < 94)
                send_item(dic_pkg::OP_READ_ALL, 6'($urandom), 8'($urandom));
            else
                send_item(OP_UNUSED, 6'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_reset_state();
        send_item(dic_pkg::OP_READ_ALL, 6'h00, 8'h00);
        send_item(dic_pkg::OP_READ_ONE, 6'h3F, 8'd0);
        send_item(dic_pkg::OP_READ_ONE, 6'h00, 8'd5);
        send_item(dic_pkg::OP_READ_ONE, 6'h15, 8'd6);
        send_item(dic_pkg::OP_READ_ONE, 6'h2A, 8'd255);
        send_item(OP_UNUSED, 6'h3F, 8'hFF);
    endtask

    task automatic test_limit_zero();
        write_limit(7'd0);
        send_item(dic_pkg::OP_TICK, 6'h00, 8'h00);
        send_item(dic_pkg::OP_READ_ALL, 6'h00, 8'h00);
        send_item(OP_UNUSED, 6'h3F, 8'h00);
        send_item(dic_pkg::OP_TICK, 6'h3F, 8'hFF);
        send_item(dic_pkg::OP_TICK, 6'h2A, 8'h00);
        send_item(dic_pkg::OP_READ_ONE, 6'h00, 8'd1);
        send_item(dic_pkg::OP_READ_ONE, 6'h00, 8'd0);
    endtask

    task automatic test_limit_one();
        write_limit(7'd1);
        send_item(dic_pkg::OP_TICK, 6'h00, 8'h00);
        send_item(dic_pkg::OP_TICK, 6'h00, 8'h00);
        send_item(dic_pkg::OP_READ_ALL, 6'h3F, 8'h00);
        send_item(dic_pkg::OP_TICK, 6'h3F, 8'h00);
        send_item(dic_pkg::OP_TICK, 6'h3F, 8'h00);
        send_item(dic_pkg::OP_TICK, 6'h15, 8'h00);
        send_item(dic_pkg::OP_READ_ALL, 6'h00, 8'h00);
    endtask

    // long holds so integrators reach the 255 ceiling and the floor of 1
    task automatic test_saturation();
        write_limit(7'd127);
        drive_mixed_traffic(500, 400);
    endtask

    // integrators start outside the narrower band
    task automatic test_limit_lowered();
        write_limit(7'd10);
        drive_mixed_traffic(250, 40);
        write_limit(7'd0);
        drive_mixed_traffic(150, 8);
        write_limit(7'd1);
        drive_mixed_traffic(150, 8);
    endtask

    task automatic test_random_limits();
        write_limit(7'($urandom_range(2, 60)));
        drive_mixed_traffic(200, 60);
    endtask

    task automatic test_steady_stream();
        write_limit(dic_pkg::LIMIT_DEFAULT);
        quiet = 1'b1;
        drive_mixed_traffic(150, 60);
    endtask

    // output channel back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        card_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction on output");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (is_response !== exp_r.is_response)
                begin
                    $error("is_response: expected %0d, got %0d", exp_r.is_response, is_response);
                    error_count++;
                end
                if (read_value !== exp_r.read_value)
                begin
                    $error("read_value: expected %0h, got %0h", exp_r.read_value, read_value);
                    error_count++;
                end
                if (led_enable !== exp_r.led_enable)
                begin
                    $error("led_enable: expected %0h, got %0h", exp_r.led_enable, led_enable);
                    error_count++;
                end
                if (led_level !== exp_r.led_level)
                begin
                    $error("led_level: expected %0h, got %0h", exp_r.led_level, led_level);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        reset_card_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_limit_zero();
        test_limit_one();
        test_saturation();
        test_limit_lowered();
        test_random_limits();
        test_steady_stream();
        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dic_pkg.sv
hdl/dic_lane.sv
hdl/dic_merge.sv
hdl/dic_out.sv
hdl/debounced_input_card.sv
sim/tb_debounced_input_card.sv
